// ===== rtl/sfl_pkg.sv =====
package sfl_pkg;

   localparam int ADDR_W       = 64;
   localparam int COUNT_W      = 11;
   localparam int INDEX_W      = 10;
   localparam int OFFSET_W     = 32;
   localparam int DEPTH_DEFAULT = 1024;

   localparam logic [ADDR_W-1:0] CANON_MASK = 64'hfffff80000000000;
   localparam logic [ADDR_W-1:0] PAGE_MASK  = 64'hfffffffffffff000;
   localparam logic [ADDR_W-1:0] ZERO_ADDR  = 64'h0000000000000000;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_MID,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                found;
      logic [INDEX_W-1:0]  symbol_index;
      logic [OFFSET_W-1:0] offset;
      logic                bad_address;
   } result_type;

   // non-canonical (bits 63..43 mixed) or within the first page
   function automatic logic bad_address_check(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] hi;
      logic              canonical;
      logic              first_page;
      hi         = a & CANON_MASK;
      canonical  = (hi == CANON_MASK) || (hi == ZERO_ADDR);
      first_page = (a & PAGE_MASK) == ZERO_ADDR;
      return !canonical || first_page;
   endfunction

endpackage

// ===== rtl/sfl_table.sv =====
module sfl_table #(
   parameter int TABLE_DEPTH = sfl_pkg::DEPTH_DEFAULT,
   parameter int AW          = $clog2(TABLE_DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [sfl_pkg::ADDR_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [sfl_pkg::ADDR_W-1:0] rd_data
);
   import sfl_pkg::*;

   logic [ADDR_W-1:0] entry_mem_ff [TABLE_DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sfl_search.sv =====
module sfl_search #(
   parameter int TABLE_DEPTH = sfl_pkg::DEPTH_DEFAULT,
   parameter int AW          = $clog2(TABLE_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic [sfl_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [sfl_pkg::ADDR_W-1:0]   req_entry_addr,
   input  logic [sfl_pkg::ADDR_W-1:0]   req_query_addr,
   input  logic [sfl_pkg::COUNT_W-1:0]  symbol_count,
   output logic                         res_valid,
   output sfl_pkg::result_type          res_data,
   input  logic                         res_free,
   output logic                         mem_wr_en,
   output logic [AW-1:0]                mem_wr_addr,
   output logic [sfl_pkg::ADDR_W-1:0]   mem_wr_data,
   output logic [AW-1:0]                mem_rd_addr,
   input  logic [sfl_pkg::ADDR_W-1:0]   mem_rd_data
);
   import sfl_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [EW-1:0] DEPTH_EXT = EW'(TABLE_DEPTH);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   query_ff, query_in;
   logic                bad_ff, bad_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       lo_ff, lo_in;
   logic [AW-1:0]       hi_ff, hi_in;
   logic [AW-1:0]       mid_ff, mid_in;
   logic [OFFSET_W-1:0] off_ff, off_in;

   logic              accept;
   logic [EW-1:0]     count_ext;
   logic [EW-1:0]     n_ext;
   logic [EW-1:0]     last_ext;
   logic              entry_ok;
   logic [ADDR_W:0]   diff;
   logic              q_below;
   logic [AW:0]       step_sum;
   logic              more;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // count clamps to the depth
   assign count_ext = EW'(symbol_count);
   assign n_ext     = (count_ext > DEPTH_EXT) ? DEPTH_EXT : count_ext;
   assign last_ext  = n_ext - EW'(1);
   assign entry_ok  = EW'(req_entry_index) < DEPTH_EXT;

   // one subtractor gives both the compare and the offset
   assign diff    = {1'b0, query_ff} - {1'b0, mem_rd_data};
   assign q_below = diff[ADDR_W];

   assign step_sum = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_in   = step_sum[AW:1];
   assign more     = ({1'b0, lo_in} + (AW+1)'(1)) < {1'b0, hi_in};

   assign mem_wr_en   = accept && (req_mode == MODE_LOAD) && entry_ok;
   assign mem_wr_addr = AW'(req_entry_index);
   assign mem_wr_data = req_entry_addr;

   always_comb begin
      case (state_ff)
         ST_FIRST: mem_rd_addr = hi_ff;
         ST_LAST,
         ST_MID:   mem_rd_addr = mid_in;
         default:  mem_rd_addr = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_LOOKUP)) begin
               state_in = (symbol_count == '0) ? ST_FINISH : ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (q_below || (hi_ff == '0)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (!q_below || !more) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            if (!more) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath; lo_ff always holds the index of the current floor candidate
   always_comb begin
      query_in = query_ff;
      bad_in   = bad_ff;
      found_in = found_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      off_in   = off_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_LOOKUP)) begin
               query_in = req_query_addr;
               bad_in   = bad_address_check(req_query_addr);
               found_in = 1'b0;
               lo_in    = '0;
               hi_in    = AW'(last_ext);
               off_in   = '0;
            end
         end
         ST_FIRST: begin
            if (!q_below) begin
               found_in = 1'b1;
               off_in   = diff[OFFSET_W-1:0];
            end
         end
         ST_LAST: begin
            if (!q_below) begin
               lo_in  = hi_ff;
               off_in = diff[OFFSET_W-1:0];
            end
         end
         ST_MID: begin
            if (q_below) begin
               hi_in = mid_ff;
            end else begin
               lo_in  = mid_ff;
               off_in = diff[OFFSET_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign res_valid              = (state_ff == ST_FINISH);
   assign res_data.found         = found_ff;
   assign res_data.symbol_index  = INDEX_W'(lo_ff);
   assign res_data.offset        = off_ff;
   assign res_data.bad_address   = bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      query_ff <= query_in;
      bad_ff   <= bad_in;
      found_ff <= found_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      off_ff   <= off_in;
   end

endmodule

// ===== rtl/symbol_floor_lookup_core.sv =====
// Floor lookup over a sorted table of 64-bit symbol start addresses.
//
// Request channel (req_*, valid/ready): req_mode selects a load word, which
// writes req_entry_addr at req_entry_index, or a lookup word, which resolves
// req_query_addr. Loads give no response; each lookup gives one response
// word on rsp_* with the floor index, the low 32 bits of the offset from
// that entry, a found flag and a bad-address flag.
// csr_wr_en/csr_wr_data set the number of valid entries; write it only
// while no lookup is in flight.
//
// A load is written into the table as it is accepted. A lookup walks a binary
// search through the table memory, which has separate read and write ports,
// one read per cycle with a registered read: accept, first entry, last entry,
// then midpoint reads that halve the range, and a hand-over state. With a zero
// count a lookup goes straight to the hand-over state.
// One lookup is in the search at a time.
// The response sits in an output register, so a new word is taken while the
// previous response waits; a further lookup holds in its last cycle until
// that register frees. Reset clears the count and the handshake state; the
// table contents are undefined until loaded.
module symbol_floor_lookup_core #(
   parameter int TABLE_DEPTH = sfl_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [sfl_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [sfl_pkg::ADDR_W-1:0]    req_entry_addr,
   input  logic [sfl_pkg::ADDR_W-1:0]    req_query_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [sfl_pkg::INDEX_W-1:0]   rsp_symbol_index,
   output logic [sfl_pkg::OFFSET_W-1:0]  rsp_offset,
   output logic                          rsp_bad_address,
   input  logic                          csr_wr_en,
   input  logic [sfl_pkg::COUNT_W-1:0]   csr_wr_data
);
   import sfl_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   logic               res_valid;
   result_type         res_data;
   logic               res_free;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [ADDR_W-1:0]  mem_wr_data;
   logic [AW-1:0]      mem_rd_addr;
   logic [ADDR_W-1:0]  mem_rd_data;

   sfl_search #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_search (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_entry_addr  (req_entry_addr),
      .req_query_addr  (req_query_addr),
      .symbol_count    (count_ff),
      .res_valid       (res_valid),
      .res_data        (res_data),
      .res_free        (res_free),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   sfl_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign count_in = csr_wr_en ? csr_wr_data : count_ff;

   // output register frees when empty or being taken this cycle
   assign res_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_data_ff.found;
   assign rsp_symbol_index = rsp_data_ff.symbol_index;
   assign rsp_offset       = rsp_data_ff.offset;
   assign rsp_bad_address  = rsp_data_ff.bad_address;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import sfl_pkg::*;

   localparam int TABLE_SIZE     = 1024;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_WORDS   = 300;
   localparam int WIDE_TABLE     = 512;

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_LOOKUP,
      ROW_COUNT
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [INDEX_W-1:0] index;
      logic [ADDR_W-1:0]  value;
      logic               typed;
      result_type         expected;
   } row_type;

   localparam result_type UNTYPED = '0;

   // value is the entry address for a load, the query for a lookup, the count for a count row
   localparam row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      '{ROW_LOOKUP, 10'd0,    64'h0000_0000_0000_0000, 1'b1, result_type'{1'b0, 10'd0, 32'd0, 1'b1}},
      '{ROW_LOOKUP, 10'd0,    64'hffff_ffff_ffff_ffff, 1'b1, result_type'{1'b0, 10'd0, 32'd0, 1'b0}},
      '{ROW_LOOKUP, 10'd0,    64'h0000_0800_0000_0000, 1'b1, result_type'{1'b0, 10'd0, 32'd0, 1'b1}},
      '{ROW_LOOKUP, 10'd0,    64'hffff_f7ff_ffff_ffff, 1'b1, result_type'{1'b0, 10'd0, 32'd0, 1'b1}},
      '{ROW_LOOKUP, 10'd0,    64'h0000_07ff_ffff_f000, 1'b1, result_type'{1'b0, 10'd0, 32'd0, 1'b0}},
      '{ROW_LOAD,   10'd0,    64'h0000_0000_0000_1000, 1'b0, UNTYPED},
      '{ROW_LOAD,   10'd1,    64'h0000_0000_0001_0000, 1'b0, UNTYPED},
      '{ROW_LOAD,   10'd2,    64'h0000_7fff_0000_0000, 1'b0, UNTYPED},
      '{ROW_LOAD,   10'd1023, 64'hffff_ffff_ffff_ffff, 1'b0, UNTYPED},
      '{ROW_LOAD,   10'd3,    64'hffff_ffff_ffff_fff0, 1'b0, UNTYPED},
      '{ROW_COUNT,  10'd0,    64'd4,                   1'b0, UNTYPED},
      '{ROW_LOOKUP, 10'd0,    64'h0000_0000_0000_0fff, 1'b1, result_type'{1'b0, 10'd0, 32'd0, 1'b1}},
      '{ROW_LOOKUP, 10'd0,    64'h0000_0000_0000_1000, 1'b1, result_type'{1'b1, 10'd0, 32'd0, 1'b0}},
      '{ROW_LOOKUP, 10'd0,    64'hffff_ffff_ffff_ffff, 1'b1, result_type'{1'b1, 10'd3, 32'hf, 1'b0}},
      '{ROW_LOOKUP, 10'd0,    64'h0000_7fff_1234_5678, 1'b0, UNTYPED},
      '{ROW_LOOKUP, 10'd0,    64'h0001_0000_0000_0000, 1'b0, UNTYPED},
      '{ROW_LOOKUP, 10'd0,    64'h0000_0001_0001_0000, 1'b0, UNTYPED},
      '{ROW_LOOKUP, 10'd0,    64'h0000_0000_0000_ffff, 1'b0, UNTYPED},
      '{ROW_LOAD,   10'd1,    64'h0000_0000_0000_0800, 1'b0, UNTYPED},
      '{ROW_LOOKUP, 10'd0,    64'h0000_0000_0000_2000, 1'b0, UNTYPED},
      '{ROW_COUNT,  10'd0,    64'd1,                   1'b0, UNTYPED},
      '{ROW_LOOKUP, 10'd0,    64'h0000_0000_0000_1000, 1'b1, result_type'{1'b1, 10'd0, 32'd0, 1'b0}},
      '{ROW_LOOKUP, 10'd0,    64'h0000_0000_0000_0fff, 1'b1, result_type'{1'b0, 10'd0, 32'd0, 1'b1}},
      '{ROW_COUNT,  10'd0,    64'd0,                   1'b0, UNTYPED},
      '{ROW_LOOKUP, 10'd0,    64'h1234_5678_9abc_def0, 1'b1, result_type'{1'b0, 10'd0, 32'd0, 1'b1}}
   };

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic                req_mode         = MODE_LOAD;
   logic [INDEX_W-1:0]  req_entry_index  = '0;
   logic [ADDR_W-1:0]   req_entry_addr   = '0;
   logic [ADDR_W-1:0]   req_query_addr   = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic                rsp_found;
   logic [INDEX_W-1:0]  rsp_symbol_index;
   logic [OFFSET_W-1:0] rsp_offset;
   logic                rsp_bad_address;
   logic                csr_wr_en        = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data      = '0;

   logic [ADDR_W-1:0] symbol_addr_table [TABLE_SIZE];
   int                symbol_count = 0;
   result_type        pending_results [$];
   int                words_sent     = 0;
   int                mismatch_count = 0;
   int                quiet_cycles   = 0;
   bit                sender_idles   = 1'b1;
   bit                rsp_idles      = 1'b1;
   bit                hold_rsp       = 1'b0;

   symbol_floor_lookup_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_entry_addr   (req_entry_addr),
      .req_query_addr   (req_query_addr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_symbol_index (rsp_symbol_index),
      .rsp_offset       (rsp_offset),
      .rsp_bad_address  (rsp_bad_address),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // floor search over the first symbol_count entries, same probe order as the block
   function automatic result_type predict_floor(input logic [ADDR_W-1:0] query);
      result_type        r;
      logic [ADDR_W-1:0] top_bits;
      logic [ADDR_W-1:0] floor_addr;
      logic [ADDR_W-1:0] distance;
      int                n;
      int                lo;
      int                hi;
      int                mid;
      r        = '0;
      top_bits = query & CANON_MASK;
      r.bad_address = !((top_bits == CANON_MASK) || (top_bits == ZERO_ADDR)) ||
                      ((query & PAGE_MASK) == ZERO_ADDR);
      n = (symbol_count > TABLE_SIZE) ? TABLE_SIZE : symbol_count;
      if (n == 0 || query < symbol_addr_table[0])
         return r;
      hi = n - 1;
      lo = hi;
      if (query < symbol_addr_table[hi]) begin
         lo = 0;
         while (lo + 1 < hi) begin
            mid = (lo + hi) >> 1;
            if (query < symbol_addr_table[mid])
               hi = mid;
            else
               lo = mid;
         end
      end
      floor_addr     = symbol_addr_table[lo];
      distance       = query - floor_addr;
      r.found        = 1'b1;
      r.symbol_index = lo[INDEX_W-1:0];
      r.offset       = distance[OFFSET_W-1:0];
      return r;
   endfunction

   task automatic send_word(input logic mode, input logic [INDEX_W-1:0] index,
                            input logic [ADDR_W-1:0] entry_addr,
                            input logic [ADDR_W-1:0] query_addr,
                            input bit typed, input result_type typed_result);
      int gap;
      gap = sender_idles ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_index <= index;
      req_entry_addr  <= entry_addr;
      req_query_addr  <= query_addr;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (mode == MODE_LOAD)
         symbol_addr_table[index] = entry_addr;
      else
         pending_results.push_back(typed ? typed_result : predict_floor(query_addr));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // loads are written as they are accepted; this wait lets the block settle
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_symbol_count(input int value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      symbol_count  = value;
   endtask

   // mostly ascending tables over a random span, some with repeats, some unsorted
   task automatic fill_symbol_table(input int n);
      logic [ADDR_W-1:0] span;
      logic [ADDR_W-1:0] step;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] pos;
      int                i;
      bit                unsorted;
      unsorted = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 2))
         0: span = '1;
         1: span = 64'h0000_0100_0000_0000;
         default: span = 64'h0000_0000_0001_0000;
      endcase
      step  = (n > 0) ? span / 64'(n) : span;
      start = (span == '1) ? ZERO_ADDR : rand64() % (~span + 64'd1);
      addr  = start;
      for (i = 0; i < n; i++) begin
         pos = 64'(i);
         if (unsorted)
            addr = rand64();
         else if (i == 0 || $urandom_range(0, 15) != 0)
            addr = start + pos * step + rand64() % step;
         send_word(MODE_LOAD, pos[INDEX_W-1:0], addr, rand64(), 1'b0, UNTYPED);
      end
   endtask

   function automatic logic [63:0] pick_query(input int n);
      logic [ADDR_W-1:0] q;
      int                i;
      int                pick;
      i    = (n > 0) ? $urandom_range(0, n - 1) : 0;
      pick = (n > 0) ? $urandom_range(0, 8) : $urandom_range(4, 8);
      case (pick)
         0: q = symbol_addr_table[i];
         1: q = symbol_addr_table[i] + 64'($urandom_range(0, 65535));
         2: q = symbol_addr_table[i] - 64'd1;
         3: q = ($urandom_range(0, 1) == 1) ?
                symbol_addr_table[0] - 64'($urandom_range(1, 4096)) :
                symbol_addr_table[n - 1] + 64'($urandom);
         4: q = rand64();
         5: q = {52'd0, 12'($urandom)};
         6: begin
            q = rand64();
            q[63:43] = 21'($urandom_range(1, 21'h1ffffe));
         end
         7: q = {21'h1fffff, 43'(rand64())};
         default: q = {21'd0, 43'(rand64())};
      endcase
      return q;
   endfunction

   task automatic run_phase(input int n, input bit hold);
      int k;
      int lookups;
      fill_symbol_table(n);
      set_symbol_count(n);
      sender_idles = hold ? 1'b0 : ($urandom_range(0, 3) != 0);
      // block the result side while lookups keep coming, so the input backs up
      if (hold)
         hold_rsp = 1'b1;
      lookups = $urandom_range(20, 60);
      for (k = 0; k < lookups; k++) begin
         if ($urandom_range(0, 7) == 0)
            send_word(MODE_LOAD, 10'($urandom_range(0, TABLE_SIZE - 1)), rand64(), rand64(),
                      1'b0, UNTYPED);
         else
            send_word(MODE_LOOKUP, 10'($urandom_range(0, TABLE_SIZE - 1)), rand64(),
                      pick_query(n), 1'b0, UNTYPED);
      end
   endtask

   initial begin
      int      r;
      int      n;
      int      phase;
      row_type row;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIRECTED_COUNT; r++) begin
         row = DIRECTED_ROWS[r];
         case (row.kind)
            ROW_COUNT: set_symbol_count(int'(row.value));
            ROW_LOAD: begin
               send_word(MODE_LOAD, row.index, row.value, rand64(), 1'b0, UNTYPED);
            end
            default: begin
               send_word(MODE_LOOKUP, 10'($urandom_range(0, TABLE_SIZE - 1)), rand64(),
                         row.value, row.typed, row.expected);
            end
         endcase
      end

      phase = 0;
      while (words_sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 15))
            0: n = 0;
            1: n = 1;
            2: n = 2;
            3, 4: n = $urandom_range(3, 8);
            default: n = $urandom_range(3, 64);
         endcase
         run_phase(n, (phase % 8) == 1);
         phase++;
      end
      run_phase(WIDE_TABLE, 1'b0);

      wait_for_drain();
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   task automatic check_field(input string name, input logic [63:0] expected,
                              input logic [63:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, expected, actual);
         mismatch_count++;
      end
   endtask

   initial begin
      int         stall;
      result_type want;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            if ($urandom_range(0, 31) == 0)
               rsp_idles = !rsp_idles;
            stall = rsp_idles ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            $display("%0t: result word with nothing expected, index %0d offset %0h",
                     $time, rsp_symbol_index, rsp_offset);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("found", 64'(want.found), 64'(rsp_found));
            check_field("symbol_index", 64'(want.symbol_index), 64'(rsp_symbol_index));
            check_field("offset", 64'(want.offset), 64'(rsp_offset));
            check_field("bad_address", 64'(want.bad_address), 64'(rsp_bad_address));
         end
      end
   end

   // cycles without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
rtl/sfl_pkg.sv
rtl/sfl_table.sv
rtl/sfl_search.sv
rtl/symbol_floor_lookup_core.sv
dv/testbench.sv
